/* hdl/tbdr_pkg.sv */
// Shared types and constants for the three-button debounce block.
`timescale 1ns / 1ps

package tbdr_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  localparam logic [CfgW-1:0] DebounceRst    = 16'd30;
  localparam logic [CfgW-1:0] RepeatDelayRst = 16'd400;
  localparam logic [CfgW-1:0] RepeatIntvRst  = 16'd120;
  localparam logic [CfgW-1:0] LongPressRst   = 16'd800;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_UP       = 3'd1,
    EV_DOWN     = 3'd2,
    EV_OK_SHORT = 3'd3,
    EV_OK_LONG  = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE     = 8'd0,
    CFG_REPEAT_DELAY = 8'd1,
    CFG_REPEAT_INTV  = 8'd2,
    CFG_LONG_PRESS   = 8'd3
  } cfg_idx_e;

  // per-button filter result for the current poll
  typedef struct packed {
    logic             press;    // clean press edge this poll
    logic             released; // clean release edge this poll
    logic             stable;   // debounced level after this poll
    logic [TimeW-1:0] held_ms;  // time since debounced press began
  } btn_status_t;

endpackage

/* hdl/tbdr_button.sv */
// Debounce filter for one button: raw tracking, stable level and press time.
`timescale 1ns / 1ps

module tbdr_button (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         level_i,
  input  logic [tbdr_pkg::TimeW-1:0]   now_i,
  input  logic [tbdr_pkg::CfgW-1:0]    debounce_i,
  output tbdr_pkg::btn_status_t        status_o
);
  import tbdr_pkg::*;

  logic             raw_seen_q, raw_seen_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_time_q, change_time_d;
  logic [TimeW-1:0] press_time_q, press_time_d;

  logic             raw_changed;
  logic [TimeW-1:0] since_change;
  logic             settle;

  always_comb begin
    raw_changed  = (level_i != raw_seen_q);
    // a fresh raw change has zero elapsed time
    since_change = raw_changed ? '0 : (now_i - change_time_q);
    settle       = (level_i != stable_q) &&
                   (since_change >= {{(TimeW-CfgW){1'b0}}, debounce_i});

    status_o.press    = settle && level_i;
    status_o.released = settle && !level_i;
    status_o.stable   = settle ? level_i : stable_q;
    status_o.held_ms  = status_o.press ? '0 : (now_i - press_time_q);

    raw_seen_d    = raw_seen_q;
    change_time_d = change_time_q;
    stable_d      = stable_q;
    press_time_d  = press_time_q;
    if (en_i) begin
      raw_seen_d = level_i;
      if (raw_changed) begin
        change_time_d = now_i;
      end
      stable_d = status_o.stable;
      if (status_o.press) begin
        press_time_d = now_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_seen_q    <= 1'b0;
      stable_q      <= 1'b0;
      change_time_q <= '0;
      press_time_q  <= '0;
    end else begin
      raw_seen_q    <= raw_seen_d;
      stable_q      <= stable_d;
      change_time_q <= change_time_d;
      press_time_q  <= press_time_d;
    end
  end

endmodule

/* hdl/three_button_debounce_repeat_longpress.sv */
// Top level: three-button debouncer with up/down auto-repeat and ok long press.
`timescale 1ns / 1ps

// One poll word in, one event word out, one poll per clock sustained while the
// output is not stalled. A poll is captured in an input register, evaluated in
// a single pass against the button state (which is updated in that same cycle)
// and lands in a result register. The result register decouples the sides: a
// new poll can be taken into an empty input register while a finished event
// waits. Times wrap modulo 2^32.
// Configuration writes are always ready; indexes above 3 are ignored.

module three_button_debounce_repeat_longpress (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: [0] up_level, [1] down_level, [2] ok_level, [34:3] now_ms, rest 0
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tbdr_pkg::InDataW-1:0]     s_axis_tdata,
  // tdata: [2:0] event_res, rest 0
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tbdr_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbdr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tbdr_pkg::CfgW-1:0]        cfg_data_i
);
  import tbdr_pkg::*;

  localparam int unsigned NowLsb = 3;

  logic [CfgW-1:0] debounce_q, repeat_delay_q, repeat_intv_q, long_press_q;

  logic             in_valid_q;
  logic             up_q, down_q, ok_q;
  logic [TimeW-1:0] now_q;

  logic             out_valid_q;
  event_e           event_q, event_d;

  logic [TimeW-1:0] repeat_time_q [2];
  logic [TimeW-1:0] repeat_time_d [2];
  logic             long_done_q, long_done_d;

  logic advance, go;
  logic up_fire, down_fire, ok_en;
  logic long_fire, long_done_eff;

  btn_status_t up_st, down_st, ok_st;

  assign advance       = !out_valid_q || m_axis_tready;
  assign go            = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DebounceRst;
      repeat_delay_q <= RepeatDelayRst;
      repeat_intv_q  <= RepeatIntvRst;
      long_press_q   <= LongPressRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:     debounce_q     <= cfg_data_i;
        CFG_REPEAT_DELAY: repeat_delay_q <= cfg_data_i;
        CFG_REPEAT_INTV:  repeat_intv_q  <= cfg_data_i;
        CFG_LONG_PRESS:   long_press_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      up_q   <= s_axis_tdata[0];
      down_q <= s_axis_tdata[1];
      ok_q   <= s_axis_tdata[2];
      now_q  <= s_axis_tdata[NowLsb +: TimeW];
    end
  end

  // down is only filtered when up stays quiet, ok only when both stay quiet
  tbdr_button u_up (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (go),
    .level_i    (up_q),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .status_o   (up_st)
  );

  tbdr_button u_down (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (go && !up_fire),
    .level_i    (down_q),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .status_o   (down_st)
  );

  tbdr_button u_ok (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (ok_en),
    .level_i    (ok_q),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .status_o   (ok_st)
  );

  always_comb begin
    up_fire = up_st.press ||
              (up_st.stable &&
               (up_st.held_ms >= {{(TimeW-CfgW){1'b0}}, repeat_delay_q}) &&
               ((now_q - repeat_time_q[0]) >= {{(TimeW-CfgW){1'b0}}, repeat_intv_q}));
    down_fire = down_st.press ||
                (down_st.stable &&
                 (down_st.held_ms >= {{(TimeW-CfgW){1'b0}}, repeat_delay_q}) &&
                 ((now_q - repeat_time_q[1]) >= {{(TimeW-CfgW){1'b0}}, repeat_intv_q}));
    ok_en = go && !up_fire && !down_fire;

    long_done_eff = ok_st.press ? 1'b0 : long_done_q;
    long_fire     = ok_st.stable && !long_done_eff &&
                    (ok_st.held_ms >= {{(TimeW-CfgW){1'b0}}, long_press_q});

    repeat_time_d[0] = repeat_time_q[0];
    repeat_time_d[1] = repeat_time_q[1];
    long_done_d      = long_done_q;
    event_d          = EV_NONE;
    if (up_fire) begin
      event_d = EV_UP;
      if (go) begin
        repeat_time_d[0] = now_q;
      end
    end else if (down_fire) begin
      event_d = EV_DOWN;
      if (go) begin
        repeat_time_d[1] = now_q;
      end
    end else begin
      if (go) begin
        long_done_d = long_done_eff;
      end
      if (long_fire) begin
        event_d = EV_OK_LONG;
        if (go) begin
          long_done_d = 1'b1;
        end
      end else if (ok_st.released && !long_done_eff) begin
        event_d = EV_OK_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_time_q[0] <= '0;
      repeat_time_q[1] <= '0;
      long_done_q      <= 1'b0;
    end else begin
      repeat_time_q[0] <= repeat_time_d[0];
      repeat_time_q[1] <= repeat_time_d[1];
      long_done_q      <= long_done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, event_q};

endmodule

/* hdl/tbdr_checker.sv */
// Port-level checks for the debounce block, bound to the top level.
`timescale 1ns / 1ps

module tbdr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tbdr_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          cfg_ready_o
);
  import tbdr_pkg::*;

  // only codes none..ok long, upper bits zero
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:3] == '0) &&
      (m_axis_tdata[2:0] == EV_NONE || m_axis_tdata[2:0] == EV_UP ||
       m_axis_tdata[2:0] == EV_DOWN || m_axis_tdata[2:0] == EV_OK_SHORT ||
       m_axis_tdata[2:0] == EV_OK_LONG))
    else $error("bad event word");

  // input side only stalls behind a stalled, full output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // input side never stalls while output drains
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready && cfg_ready_o |-> s_axis_tready)
    else $error("input stalled while output ready");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

endmodule

bind three_button_debounce_repeat_longpress tbdr_checker u_tbdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
